// ===== sv/pwd_pkg.sv =====
// Shared types, constants and the receive substitution table for the word decipher block.
package pwd_pkg;

	localparam logic [31:0] PACKET_KEY = 32'hA66A_A66A;
	localparam logic [31:0] LCG_MUL = 32'd241103;
	localparam logic [31:0] LCG_ADD = 32'd2533101;
	localparam int unsigned LANES = 4;
	localparam logic [2:0] FULL_WORD = 3'd4;
	localparam logic [2:0] ROUND_STEP = 3'd3;

	typedef struct packed {
		logic [31:0] cipher_word;
		logic [2:0]  valid_bytes;
		logic        first_of_packet;
		logic        last_of_packet;
		logic [7:0]  check_code;
		logic        load_key;
	} in_req_t;

	typedef struct packed {
		logic [31:0] plain_word;
		logic [2:0]  out_valid_bytes;
		logic        out_last;
		logic [7:0]  check_sum;
	} out_rsp_t;

	// One classified word waiting for the byte stage.
	typedef struct packed {
		logic [31:0] xword;
		logic [2:0]  nbytes;
		logic        first;
		logic        last;
		logic [7:0]  code;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [7:0] RX_SUB [256] = '{
		8'h51, 8'hA1, 8'h9E, 8'hB0, 8'h1E, 8'h83, 8'h1C, 8'h2D,
		8'hE9, 8'h77, 8'h3D, 8'h13, 8'h93, 8'h10, 8'h45, 8'hFF,
		8'h6D, 8'hC9, 8'h20, 8'h2F, 8'h1B, 8'h82, 8'h1A, 8'h7D,
		8'hF5, 8'hCF, 8'h52, 8'hA8, 8'hD2, 8'hA4, 8'hB4, 8'h0B,
		8'h31, 8'h97, 8'h57, 8'h19, 8'h34, 8'hDF, 8'h5B, 8'h41,
		8'h58, 8'h49, 8'hAA, 8'h5F, 8'h0A, 8'hEF, 8'h88, 8'h01,
		8'hDC, 8'h95, 8'hD4, 8'hAF, 8'h7B, 8'hE3, 8'h11, 8'h8E,
		8'h9D, 8'h16, 8'h61, 8'h8C, 8'h84, 8'h3C, 8'h1F, 8'h5A,
		8'h02, 8'h4F, 8'h39, 8'hFE, 8'h04, 8'h07, 8'h5C, 8'h8B,
		8'hEE, 8'h66, 8'h33, 8'hC4, 8'hC8, 8'h59, 8'hB5, 8'h5D,
		8'hC2, 8'h6C, 8'hF6, 8'h4D, 8'hFB, 8'hAE, 8'h4A, 8'h4B,
		8'hF3, 8'h35, 8'h2C, 8'hCA, 8'h21, 8'h78, 8'h3B, 8'h03,
		8'hFD, 8'h24, 8'hBD, 8'h25, 8'h37, 8'h29, 8'hAC, 8'h4E,
		8'hF9, 8'h92, 8'h3A, 8'h32, 8'h4C, 8'hDA, 8'h06, 8'h5E,
		8'h00, 8'h94, 8'h60, 8'hEC, 8'h17, 8'h98, 8'hD7, 8'h3E,
		8'hCB, 8'h6A, 8'hA9, 8'hD9, 8'h9C, 8'hBB, 8'h08, 8'h8F,
		8'h40, 8'hA0, 8'h6F, 8'h55, 8'h67, 8'h87, 8'h54, 8'h80,
		8'hB2, 8'h36, 8'h47, 8'h22, 8'h44, 8'h63, 8'h05, 8'h6B,
		8'hF0, 8'h0F, 8'hC7, 8'h90, 8'hC5, 8'h65, 8'hE2, 8'h64,
		8'hFA, 8'hD5, 8'hDB, 8'h12, 8'h7A, 8'h0E, 8'hD8, 8'h7E,
		8'h99, 8'hD1, 8'hE8, 8'hD6, 8'h86, 8'h27, 8'hBF, 8'hC1,
		8'h6E, 8'hDE, 8'h9A, 8'h09, 8'h0D, 8'hAB, 8'hE1, 8'h91,
		8'h56, 8'hCD, 8'hB3, 8'h76, 8'h0C, 8'hC3, 8'hD3, 8'h9F,
		8'h42, 8'hB6, 8'h9B, 8'hE5, 8'h23, 8'hA7, 8'hAD, 8'h18,
		8'hC6, 8'hF4, 8'hB8, 8'hBE, 8'h15, 8'h43, 8'h70, 8'hE0,
		8'hE7, 8'hBC, 8'hF1, 8'hBA, 8'hA5, 8'hA6, 8'h53, 8'h75,
		8'hE4, 8'hEB, 8'hE6, 8'h85, 8'h14, 8'h48, 8'hDD, 8'h38,
		8'h2A, 8'hCC, 8'h7F, 8'hB1, 8'hC0, 8'h71, 8'h96, 8'hF8,
		8'h3F, 8'h28, 8'hF2, 8'h69, 8'h74, 8'h68, 8'hB7, 8'hA3,
		8'h50, 8'hD0, 8'h79, 8'h1D, 8'hFC, 8'hCE, 8'h8A, 8'h8D,
		8'h2E, 8'h62, 8'h30, 8'hEA, 8'hED, 8'h2B, 8'h26, 8'hB9,
		8'h81, 8'h7C, 8'h46, 8'h89, 8'h73, 8'hA2, 8'hF7, 8'h72
	};

	// Upper half of the 32-bit LCG step on one 16-bit half word.
	function automatic logic [15:0] half_lcg(input logic [15:0] s);
		logic [31:0] v;
		v = {16'd0, s} * LCG_MUL + LCG_ADD;
		return v[31:16];
	endfunction

endpackage

// ===== sv/pwd_front.sv =====
// Front stage: holds the key, pads short words, derives the next key and strips the XOR layer.
module pwd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [31:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  pwd_pkg::in_req_t in_req,
	input  pwd_pkg::q_stat_t q_stat,
	output logic             push,
	output pwd_pkg::work_t   push_data
);

	logic [31:0] initial_key_q;
	logic [31:0] key_q;
	logic [31:0] cur_key;
	logic [31:0] padded;
	logic [31:0] next_key;
	logic [2:0]  nbytes;

	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		// Out-of-range counts mean a full word.
		if (in_req.valid_bytes == 3'd0 || in_req.valid_bytes > pwd_pkg::FULL_WORD) begin
			nbytes = pwd_pkg::FULL_WORD;
		end else begin
			nbytes = in_req.valid_bytes;
		end
		cur_key = in_req.load_key ? initial_key_q : key_q;
		for (int i = 0; i < pwd_pkg::LANES; i++) begin
			if (3'(i) < nbytes) begin
				padded[8*i +: 8] = in_req.cipher_word[8*i +: 8];
			end else begin
				padded[8*i +: 8] = cur_key[8*i +: 8];
			end
		end
		next_key = {pwd_pkg::half_lcg(padded[31:16]), pwd_pkg::half_lcg(padded[15:0])}
			^ pwd_pkg::PACKET_KEY;
		push_data.xword  = padded ^ cur_key;
		push_data.nbytes = nbytes;
		push_data.first  = in_req.first_of_packet;
		push_data.last   = in_req.last_of_packet;
		push_data.code   = in_req.check_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_key_q <= '0;
			key_q         <= '0;
		end else begin
			if (cfg_valid) begin
				initial_key_q <= cfg_data;
			end
			if (push) begin
				key_q <= next_key;
			end
		end
	end

endmodule

// ===== sv/pwd_fifo.sv =====
// Short register queue between the front and byte stages.
module pwd_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pwd_pkg::work_t   push_data,
	input  logic             pop,
	output pwd_pkg::work_t   pop_data,
	output pwd_pkg::q_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	pwd_pkg::work_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/pwd_back.sv =====
// Byte stage: substitution, rolling round offset, running checksum and the output register.
module pwd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pwd_pkg::q_stat_t  q_stat,
	input  pwd_pkg::work_t    head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output pwd_pkg::out_rsp_t out_rsp
);

	logic [7:0]        round_q;
	logic [7:0]        sum_q;
	logic              out_valid_q;
	pwd_pkg::out_rsp_t out_rsp_q;
	logic [7:0]        sum_next;
	logic [7:0]        round_next;
	logic [31:0]       plain;
	logic [7:0]        lane_p;

	assign pop       = !q_stat.empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	always_comb begin
		sum_next = head.first ? head.code : sum_q;
		plain    = '0;
		lane_p   = '0;
		for (int i = 0; i < pwd_pkg::LANES; i++) begin
			lane_p = pwd_pkg::RX_SUB[head.xword[8*i +: 8]]
				- (round_q + 8'(pwd_pkg::ROUND_STEP * i));
			if (3'(i) < head.nbytes) begin
				plain[8*i +: 8] = lane_p;
				sum_next        = sum_next + lane_p;
			end
		end
		round_next = round_q + 8'({head.nbytes, 1'b0}) + 8'(head.nbytes);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				round_q     <= round_next;
				sum_q       <= sum_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_rsp_q.plain_word      <= plain;
			out_rsp_q.out_valid_bytes <= head.nbytes;
			out_rsp_q.out_last        <= head.last;
			out_rsp_q.check_sum       <= sum_next;
		end
	end

endmodule

// ===== sv/packet_word_decipher_core.sv =====
// Top level of the packet word decipher: front stage, word queue and byte stage.
//
// Channels: in_valid/in_ready/in_req carries one little-endian ciphertext body word
// per request; out_valid/out_ready/out_rsp returns one deciphered word per request,
// in order. cfg_valid/cfg_data writes the session key used by words that set
// load_key; cfg_ready is always high. Write it only while no word is in flight.
// A word accepted on in_req is written to the queue, then popped into the output register.
// Throughput: one word per cycle while out_ready is high. The key update (two 16x18 constant multiplies)
// is computed combinationally in the front stage; the round and checksum update (four table
// reads and a four-byte add chain) is computed combinationally in the byte stage.
// Stall: when out_ready is low the result holds in the output register; the queue
// of QUEUE_DEPTH words keeps in_ready high until it fills.
// Reset: key, session key, round and checksum clear to zero, queue and output empty.
module packet_word_decipher_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  pwd_pkg::in_req_t  in_req,
	output logic              out_valid,
	input  logic              out_ready,
	output pwd_pkg::out_rsp_t out_rsp
);

	pwd_pkg::q_stat_t q_stat;
	pwd_pkg::work_t   push_data;
	pwd_pkg::work_t   head;
	logic             push;
	logic             pop;

	assign cfg_ready = 1'b1;

	pwd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	pwd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.stat      (q_stat)
	);

	pwd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp)
	);

`ifndef SYNTHESIS
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty at once");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("popped word did not reach the output register");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_rsp.out_valid_bytes != 3'd0 && out_rsp.out_valid_bytes <= 3'd4))
		else $error("byte count out of range on output");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_rsp.out_valid_bytes == 3'd1) |-> (out_rsp.plain_word[31:8] == 24'd0))
		else $error("padding lanes not zero");
`endif

endmodule
